/* hdl/tile_dedup_with_flip_match_core_assert.svh */
// Assertion macros for the tile dedup core
`ifndef TILE_DEDUP_WITH_FLIP_MATCH_CORE_ASSERT_SVH
`define TILE_DEDUP_WITH_FLIP_MATCH_CORE_ASSERT_SVH
// check a property on every clock edge outside reset
`define TDF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check a property on every clock edge, reset included
`define TDF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

/* hdl/tdf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package tdf_pkg;
  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_READ,
    ST_CMP,
    ST_NEXT,
    ST_COPY,
    ST_DONE
  } tdf_state_t;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic [1:0] FLIP_NONE = 2'd0;
  localparam logic [1:0] FLIP_H    = 2'd1;
  localparam logic [1:0] FLIP_V    = 2'd2;
  localparam logic [1:0] FLIP_HV   = 2'd3;
endpackage
`default_nettype wire

/* hdl/tdf_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module tdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* hdl/tile_dedup_with_flip_match_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Tile deduplicator with mirror matching.
// Input channel: a beat is taken when in_start is high and in_busy is low.
// in_command = 0 carries one pixel (in_pixel) of the current tile in raster
// order; in_command = 1 empties the tile store and drops a partial tile.
// A beat other than a tile's last pixel leaves in_busy low. The last pixel
// of a tile starts a search over the stored tiles; in_busy is high until
// the result is shown. Each stored tile is tested for exact, horizontal,
// vertical and both-axis matches, with the four tests run side by side
// from the store RAM's single read port: a read state and a compare state
// per pixel, with early exit once all four tests have failed. A miss
// appends the tile, copying TILE_W*TILE_H pixels from the incoming buffer
// RAM, one per cycle. Mismatching tiles typically fail within a few pixels.
// Results appear on out_* for one cycle, marked by out_valid; the receiver
// cannot stall. Reset empties the store and the incoming tile at once; store
// contents are undefined until written and are read only below the count.
module tile_dedup_with_flip_match_core
  import tdf_pkg::*;
#(
  parameter int TILE_W    = 8,
  parameter int TILE_H    = 8,
  parameter int MAX_TILES = 1024
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_start,
  output logic            in_busy,
  input  wire logic       in_command,
  input  wire logic [7:0] in_pixel,
  output logic            out_valid,
  output logic [9:0]      out_tile_slot,
  output logic [1:0]      out_flip,
  output logic            out_is_new,
  output logic            out_store_full
);
  localparam int PIX = TILE_W * TILE_H;
  localparam int PW  = $clog2(PIX);
  localparam int XW  = $clog2(TILE_W);
  localparam int YW  = $clog2(TILE_H);
  localparam int TW  = $clog2(MAX_TILES);
  localparam int CW  = $clog2(MAX_TILES + 1);
  localparam int SD  = MAX_TILES * (1 << PW);
  localparam int SA  = TW + PW;

  tdf_state_t state_r, state_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [TW-1:0] tidx_r, tidx_nxt;
  logic [XW-1:0] x_r, x_nxt;
  logic [YW-1:0] y_r, y_nxt;
  logic [3:0]    ok_r, ok_nxt;
  logic          lastc_r, lastc_nxt;
  logic          copy_we_r, copy_we_nxt;
  logic [PW-1:0] copy_wa_r, copy_wa_nxt;
  logic          ov_r, ov_nxt;
  logic [9:0]    oslot_r, oslot_nxt;
  logic [1:0]    oflip_r, oflip_nxt;
  logic          onew_r, onew_nxt;
  logic          ofull_r, ofull_nxt;

  logic          accept;
  logic [7:0]    inc_q [4];
  logic [PW-1:0] inc_ra [4];
  logic [7:0]    st_q;
  logic [SA-1:0] st_ra;
  logic [3:0]    eq;
  logic          last_pix;

  assign accept   = in_start && (state_r == ST_COLLECT);
  assign in_busy  = (state_r != ST_COLLECT);
  assign last_pix = (x_r == XW'(TILE_W - 1)) && (y_r == YW'(TILE_H - 1));

  // incoming tile: four copies, one per flip mode, read at mirrored spots
  for (genvar m = 0; m < 4; m++) begin : g_inc
    logic [XW-1:0] sx;
    logic [YW-1:0] sy;
    assign sx = ((m & 1) != 0) ? XW'(TILE_W - 1) - x_r : x_r;
    assign sy = ((m & 2) != 0) ? YW'(TILE_H - 1) - y_r : y_r;
    assign inc_ra[m] = (state_r == ST_COPY) ? copy_wa_nxt
                     : PW'(PW'(sy) * PW'(TILE_W) + PW'(sx));
    tdf_ram #(.WIDTH(8), .DEPTH(1 << PW)) u_inc (
      .clk(clk), .we(accept && in_command == CMD_PIXEL),
      .waddr(pos_r), .wdata(in_pixel), .raddr(inc_ra[m]), .rdata(inc_q[m])
    );
  end

  // stored tiles, one row of 2^PW per slot
  assign st_ra = {tidx_r, PW'(PW'(y_r) * PW'(TILE_W) + PW'(x_r))};
  tdf_ram #(.WIDTH(8), .DEPTH(SD)) u_store (
    .clk(clk), .we(copy_we_r), .waddr({cnt_r[TW-1:0], copy_wa_r}),
    .wdata(inc_q[0]), .raddr(st_ra), .rdata(st_q)
  );

  for (genvar m = 0; m < 4; m++) begin : g_eq
    assign eq[m] = ok_r[m] && (st_q == inc_q[m]);
  end

  // hold state and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_COLLECT;
      pos_r     <= '0;
      cnt_r     <= '0;
      copy_we_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pos_r     <= pos_nxt;
      cnt_r     <= cnt_nxt;
      copy_we_r <= copy_we_nxt;
      ov_r      <= ov_nxt;
    end
    tidx_r    <= tidx_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    ok_r      <= ok_nxt;
    lastc_r   <= lastc_nxt;
    copy_wa_r <= copy_wa_nxt;
    oslot_r   <= oslot_nxt;
    oflip_r   <= oflip_nxt;
    onew_r    <= onew_nxt;
    ofull_r   <= ofull_nxt;
  end

  // sequence collect, search and append
  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    cnt_nxt     = cnt_r;
    tidx_nxt    = tidx_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    ok_nxt      = ok_r;
    lastc_nxt   = lastc_r;
    copy_we_nxt = 1'b0;
    copy_wa_nxt = copy_wa_r;
    ov_nxt      = 1'b0;
    oslot_nxt   = oslot_r;
    oflip_nxt   = oflip_r;
    onew_nxt    = onew_r;
    ofull_nxt   = ofull_r;
    case (state_r)
      ST_COLLECT: begin
        if (accept) begin
          if (in_command == CMD_CLEAR) begin
            cnt_nxt = '0;
            pos_nxt = '0;
          end else if (pos_r == PW'(PIX - 1)) begin
            pos_nxt   = '0;
            tidx_nxt  = '0;
            x_nxt     = '0;
            y_nxt     = '0;
            ok_nxt    = 4'hF;
            state_nxt = ST_NEXT;
          end else begin
            pos_nxt = pos_r + 1'b1;
          end
        end
      end
      ST_NEXT: begin
        // start the next stored tile or finish the search
        if (CW'(tidx_r) < cnt_r && !(tidx_r == '0 && ok_r == 4'h0)) begin
          x_nxt     = '0;
          y_nxt     = '0;
          ok_nxt    = 4'hF;
          state_nxt = ST_READ;
        end else if (cnt_r >= CW'(MAX_TILES)) begin
          ov_nxt = 1'b1; oslot_nxt = '0; oflip_nxt = FLIP_NONE;
          onew_nxt = 1'b0; ofull_nxt = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          copy_wa_nxt = '0;
          state_nxt   = ST_COPY;
        end
      end
      ST_READ: begin
        // mark the last pixel of the tile, and advance the raster position unless at the last pixel
        state_nxt = ST_CMP;
        lastc_nxt = last_pix;
        if (last_pix) begin
          x_nxt = x_r;
        end else if (x_r == XW'(TILE_W - 1)) begin
          x_nxt = '0;
          y_nxt = y_r + 1'b1;
        end else begin
          x_nxt = x_r + 1'b1;
        end
      end
      ST_CMP: begin
        // compare the pixel read in the previous cycle
        ok_nxt = eq;
        if (eq == 4'h0) begin
          if (CW'(tidx_r) + 1'b1 >= cnt_r) begin
            tidx_nxt = '0;
            ok_nxt   = 4'h0;
          end else begin
            tidx_nxt = tidx_r + 1'b1;
            ok_nxt   = 4'hF;
          end
          state_nxt = ST_NEXT;
        end else if (lastc_r) begin
          ov_nxt    = 1'b1;
          oslot_nxt = 10'(tidx_r);
          oflip_nxt = eq[0] ? FLIP_NONE : eq[1] ? FLIP_H : eq[2] ? FLIP_V : FLIP_HV;
          onew_nxt  = 1'b0;
          ofull_nxt = 1'b0;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_COPY: begin
        // write incoming pixels into the new slot, one a cycle
        copy_we_nxt = 1'b1;
        copy_wa_nxt = copy_wa_r;
        if (copy_we_r) begin
          if (copy_wa_r == PW'(PIX - 1)) begin
            copy_we_nxt = 1'b0;
            ov_nxt    = 1'b1;
            oslot_nxt = 10'(cnt_r);
            oflip_nxt = FLIP_NONE;
            onew_nxt  = 1'b1;
            ofull_nxt = 1'b0;
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = ST_DONE;
          end else begin
            copy_wa_nxt = copy_wa_r + 1'b1;
          end
        end
      end
      ST_DONE: state_nxt = ST_COLLECT;
      default: state_nxt = ST_COLLECT;
    endcase
  end

  assign out_valid      = ov_r;
  assign out_tile_slot  = oslot_r;
  assign out_flip       = oflip_r;
  assign out_is_new     = onew_r;
  assign out_store_full = ofull_r;

`include "tile_dedup_with_flip_match_core_assert.svh"
  `TDF_ASSERT(a_full_bound, cnt_r <= CW'(MAX_TILES), "tile count beyond store size")
  `TDF_ASSERT(a_out_busy, out_valid |-> $past(in_busy), "result without a search")
  `TDF_ASSERT(a_new_excl, out_valid |-> !(out_is_new && out_store_full), "new and full")
  `TDF_ASSERT_ALWAYS(a_rst, !rst_n |=> !out_valid, "result right after reset")
endmodule
`default_nettype wire

/* tb/tile_dedup_with_flip_match_core_tb.sv */
`timescale 1ns / 1ps
module tile_dedup_with_flip_match_core_tb;
  import tdf_pkg::*;

  localparam int TW = 8;
  localparam int TH = 8;
  localparam int NPIX = TW * TH;
  localparam int NSLOTS = 1024;
  localparam int CYCLE_LIMIT = 20_000_000;

  typedef logic [7:0] tile_t [NPIX];
  typedef struct packed {
    logic [9:0] slot;
    logic [1:0] flip;
    logic       is_new;
    logic       full;
  } tile_result_t;

  logic       clk;
  logic       rst_n;
  logic       in_start;
  logic       in_busy;
  logic       in_command;
  logic [7:0] in_pixel;
  logic       out_valid;
  logic [9:0] out_tile_slot;
  logic [1:0] out_flip;
  logic       out_is_new;
  logic       out_store_full;

  tile_dedup_with_flip_match_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_start      (in_start),
    .in_busy       (in_busy),
    .in_command    (in_command),
    .in_pixel      (in_pixel),
    .out_valid     (out_valid),
    .out_tile_slot (out_tile_slot),
    .out_flip      (out_flip),
    .out_is_new    (out_is_new),
    .out_store_full(out_store_full)
  );

  // Shadow of the tile store and the tile being collected
  logic [7:0]   saved_tiles [NSLOTS][NPIX];
  int unsigned  saved_count;
  logic [7:0]   gather [NPIX];
  int unsigned  gather_pos;
  tile_result_t pending_results [$];

  bit          failed;
  int unsigned max_gap;
  int unsigned cycle_count;
  int unsigned n_tiles, n_hits, n_new, n_full, n_clears;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Compare stored tile t with the gathered tile under a mirror mode
  function automatic bit mirrored_equal(int unsigned t, logic [1:0] mode);
    int sy;
    int sx;
    for (int y = 0; y < TH; y++) begin
      sy = mode[1] ? (TH - 1 - y) : y;
      for (int x = 0; x < TW; x++) begin
        sx = mode[0] ? (TW - 1 - x) : x;
        if (saved_tiles[t][y * TW + x] != gather[sy * TW + sx]) return 0;
      end
    end
    return 1;
  endfunction

  // Advance the shadow state by one accepted beat
  function automatic void dedup_beat(logic cmd, logic [7:0] pix);
    tile_result_t r;
    if (cmd == CMD_CLEAR) begin
      saved_count = 0;
      gather_pos = 0;
      n_clears++;
      return;
    end
    gather[gather_pos] = pix;
    gather_pos++;
    if (gather_pos < NPIX) return;
    gather_pos = 0;
    n_tiles++;
    for (int unsigned t = 0; t < saved_count; t++) begin
      for (int m = 0; m < 4; m++) begin
        if (mirrored_equal(t, 2'(m))) begin
          r = '{slot: 10'(t), flip: 2'(m), is_new: 1'b0, full: 1'b0};
          pending_results = {pending_results, r};
          n_hits++;
          return;
        end
      end
    end
    if (saved_count >= NSLOTS) begin
      r = '{slot: 10'd0, flip: FLIP_NONE, is_new: 1'b0, full: 1'b1};
      n_full++;
    end else begin
      for (int i = 0; i < NPIX; i++) saved_tiles[saved_count][i] = gather[i];
      r = '{slot: 10'(saved_count), flip: FLIP_NONE, is_new: 1'b1, full: 1'b0};
      saved_count++;
      n_new++;
    end
    pending_results = {pending_results, r};
  endfunction

  // Send one beat; called and returns at a falling edge
  task automatic send_beat(logic cmd, logic [7:0] pix);
    int unsigned gap;
    in_start = 1'b1;
    in_command = cmd;
    in_pixel = pix;
    forever begin
      @(posedge clk);
      if (!in_busy) break;
    end
    dedup_beat(cmd, pix);
    @(negedge clk);
    gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
    if (gap > 0) begin
      in_start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_tile(tile_t t);
    for (int i = 0; i < NPIX; i++) send_beat(CMD_PIXEL, t[i]);
  endtask

  function automatic tile_t mirror(tile_t t, logic [1:0] mode);
    tile_t m;
    for (int y = 0; y < TH; y++)
      for (int x = 0; x < TW; x++)
        m[y * TW + x] = t[(mode[1] ? TH - 1 - y : y) * TW + (mode[0] ? TW - 1 - x : x)];
    return m;
  endfunction

  function automatic tile_t rand_tile(int unsigned hi);
    tile_t t;
    for (int i = 0; i < NPIX; i++) t[i] = 8'($urandom_range(0, hi));
    return t;
  endfunction

  function automatic tile_t flat_tile(logic [7:0] v);
    tile_t t;
    for (int i = 0; i < NPIX; i++) t[i] = v;
    return t;
  endfunction

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: slot %0d flip %0d", out_tile_slot, out_flip);
        failed = 1;
      end else begin
        tile_result_t e;
        e = pending_results.pop_front();
        if (out_tile_slot !== e.slot) begin
          $error("tile_slot: expected %0d, got %0d", e.slot, out_tile_slot);
          failed = 1;
        end
        if (out_flip !== e.flip) begin
          $error("flip: expected %0d, got %0d", e.flip, out_flip);
          failed = 1;
        end
        if (out_is_new !== e.is_new) begin
          $error("is_new: expected %0d, got %0d", e.is_new, out_is_new);
          failed = 1;
        end
        if (out_store_full !== e.full) begin
          $error("store_full: expected %0d, got %0d", e.full, out_store_full);
          failed = 1;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Flat tiles at both extremes, every mirror, a dropped partial tile
  task automatic test_directed();
    tile_t a;
    a = rand_tile(255);
    a[0] = 8'h00;
    a[7] = 8'hff;
    send_tile(flat_tile(8'h00));
    send_tile(flat_tile(8'hff));
    send_tile(flat_tile(8'h00));
    send_tile(a);
    for (int m = 0; m < 4; m++) send_tile(mirror(a, 2'(m)));
    for (int i = 0; i < 20; i++) send_beat(CMD_PIXEL, 8'(i));
    send_beat(CMD_CLEAR, 8'hff);
    send_tile(a);
    send_beat(CMD_CLEAR, 8'h00);
    send_beat(CMD_CLEAR, 8'h5a);
  endtask

  // Mirrored repeats of a small pool, near misses, fresh tiles and noise
  task automatic test_random(int unsigned n_rounds);
    tile_t pool [8];
    tile_t t;
    int unsigned pick;
    for (int i = 0; i < 8; i++) pool[i] = rand_tile(($urandom_range(0, 1) != 0) ? 255 : 3);
    for (int unsigned r = 0; r < n_rounds; r++) begin
      max_gap = ($urandom_range(0, 3) == 0) ? 0 : 8;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_tile(mirror(pool[$urandom_range(0, 7)], 2'($urandom_range(0, 3))));
      end else if (pick < 60) begin
        t = mirror(pool[$urandom_range(0, 7)], 2'($urandom_range(0, 3)));
        t[$urandom_range(0, NPIX - 1)] = 8'($urandom);
        send_tile(t);
      end else if (pick < 85) begin
        t = rand_tile(($urandom_range(0, 1) != 0) ? 255 : 1);
        pool[$urandom_range(0, 7)] = t;
        send_tile(t);
      end else if (pick < 95) begin
        repeat ($urandom_range(1, NPIX - 1)) send_beat(CMD_PIXEL, 8'($urandom));
        send_beat(CMD_CLEAR, 8'($urandom));
      end else begin
        send_beat(CMD_CLEAR, 8'($urandom));
      end
    end
  endtask

  initial begin
    int unsigned wait_cycles;
    failed = 0;
    max_gap = 8;
    cycle_count = 0;
    saved_count = 0;
    gather_pos = 0;
    n_tiles = 0; n_hits = 0; n_new = 0; n_full = 0; n_clears = 0;
    in_start = 1'b0;
    in_command = CMD_PIXEL;
    in_pixel = 8'h00;
    rst_n = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(24);

    // Drain outstanding results, then let the pipeline settle
    in_start = 1'b0;
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 200_000) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      failed = 1;
    end
    repeat (200) @(posedge clk);

    $display("Covered %0d tiles: %0d hits, %0d appended, %0d on a full store, %0d clears.",
             n_tiles, n_hits, n_new, n_full, n_clears);
    if (!failed) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
